### src/blg_pkg.sv
// Package for the battery level gauge: shared constants, code names,
// the voltage-to-percent tables and the structs passed between modules.
// No dependencies.
package blg_pkg;

  // Fixed field widths.
  localparam int TIME_W    = 32;
  localparam int SEC_W     = 8;
  localparam int ADC_W     = 10;
  localparam int PCT_W     = 7;
  localparam int CSEC_W    = 14;
  localparam int MCNT_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Lookup table sizing.
  localparam int TABLE_CAP            = 128;
  localparam int TABLE_LEVELS_DEFAULT = 72;

  // Item modes.
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_STEP_MS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_INTERVAL_SEC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BATTERY_PERCENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_ADC_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CHARGE_SECONDS  = 3'd4;

  // Configuration reset values.
  localparam logic [TIME_W-1:0] CHARGE_STEP_MS_RST       = 32'd72000;
  localparam logic [SEC_W-1:0]  MEASURE_INTERVAL_SEC_RST = 8'd15;
  localparam logic [PCT_W-1:0]  LOW_BATTERY_PERCENT_RST  = 7'd10;
  localparam logic [ADC_W-1:0]  SHUTDOWN_ADC_LEVEL_RST   = 10'd492;
  localparam logic [CSEC_W-1:0] FULL_CHARGE_SECONDS_RST  = 14'd10000;

  // Behavioral constants.
  localparam logic [CSEC_W-1:0] CHARGE_SEC_MAX     = 14'd10800;
  localparam logic [CSEC_W-1:0] HOLD_FLOOR_SEC     = 14'd8200;
  localparam logic [TIME_W:0]   LOW_POWER_DELAY_MS = 33'd5000;
  localparam logic [MCNT_W-1:0] MEASURE_TIMEOUT    = 9'd10;
  localparam logic [MCNT_W-1:0] COUNTER_MAX        = 9'd511;
  localparam logic [PCT_W-1:0]  PCT_ROUND_UP       = 7'd95;
  localparam logic [PCT_W-1:0]  PCT_HOLD           = 7'd99;
  localparam logic [PCT_W-1:0]  PCT_FULL           = 7'd100;

  // Voltage thresholds, falling; entries past the populated part are zero.
  localparam logic [ADC_W-1:0] VOLT_STEPS [TABLE_CAP] = '{
    10'd645, 10'd641, 10'd639, 10'd637, 10'd636, 10'd634, 10'd632, 10'd630,
    10'd628, 10'd627, 10'd625, 10'd624, 10'd622, 10'd620, 10'd618, 10'd616,
    10'd614, 10'd613, 10'd612, 10'd610, 10'd609, 10'd608, 10'd606, 10'd605,
    10'd603, 10'd602, 10'd601, 10'd599, 10'd598, 10'd596, 10'd595, 10'd594,
    10'd593, 10'd592, 10'd591, 10'd590, 10'd589, 10'd588, 10'd587, 10'd586,
    10'd586, 10'd585, 10'd584, 10'd584, 10'd583, 10'd583, 10'd582, 10'd581,
    10'd581, 10'd580, 10'd580, 10'd579, 10'd579, 10'd578, 10'd578, 10'd578,
    10'd577, 10'd576, 10'd576, 10'd575, 10'd574, 10'd573, 10'd572, 10'd570,
    10'd569, 10'd567, 10'd567, 10'd566, 10'd566, 10'd566, 10'd565, 10'd564,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };

  // Percent that goes with each threshold.
  localparam logic [PCT_W-1:0] PCT_STEPS [TABLE_CAP] = '{
    7'd100, 7'd99, 7'd98, 7'd96, 7'd95, 7'd94, 7'd92, 7'd91,
    7'd89, 7'd88, 7'd87, 7'd85, 7'd84, 7'd82, 7'd81, 7'd80,
    7'd78, 7'd77, 7'd75, 7'd74, 7'd73, 7'd71, 7'd70, 7'd69,
    7'd67, 7'd66, 7'd64, 7'd63, 7'd62, 7'd60, 7'd59, 7'd57,
    7'd56, 7'd55, 7'd53, 7'd52, 7'd50, 7'd49, 7'd48, 7'd46,
    7'd45, 7'd44, 7'd42, 7'd41, 7'd39, 7'd38, 7'd37, 7'd35,
    7'd34, 7'd32, 7'd31, 7'd30, 7'd28, 7'd27, 7'd25, 7'd24,
    7'd23, 7'd21, 7'd20, 7'd19, 7'd17, 7'd16, 7'd14, 7'd13,
    7'd12, 7'd10, 7'd9, 7'd7, 7'd6, 7'd5, 7'd3, 7'd2,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  typedef struct packed {
    logic [TIME_W-1:0] charge_step_ms;
    logic [SEC_W-1:0]  measure_interval_sec;
    logic [PCT_W-1:0]  low_battery_percent;
    logic [ADC_W-1:0]  shutdown_adc_level;
    logic [CSEC_W-1:0] full_charge_seconds;
  } blg_cfg_t;

  // One accepted item, with its sample already turned into a percent.
  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] time_ms;
    logic [SEC_W-1:0]  elapsed_sec;
    logic              charger_present;
    logic [ADC_W-1:0]  adc_reading;
    logic              authorized;
    logic              low_power_mode;
    logic [TIME_W-1:0] low_power_since_ms;
    logic [PCT_W-1:0]  adc_percent;
  } blg_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] battery_percent;
    logic             charging;
    logic             low_battery;
    logic             start_measure;
    logic             shutdown_request;
    logic             display_wake;
    logic             exit_low_power;
  } blg_result_t;

endpackage

### src/blg_pct_lookup.sv
// Voltage-to-percent conversion of one ADC sample through the constant tables.
// Depends on blg_pkg.
module blg_pct_lookup
  import blg_pkg::*;
#(
  parameter int TABLE_LEVELS = TABLE_LEVELS_DEFAULT
) (
  input  logic [ADC_W-1:0] adc_reading,
  output logic [PCT_W-1:0] adc_percent
);

  logic [PCT_W-1:0] hit_pct;

  // The first entry whose threshold the sample exceeds wins; scanning from the
  // far end lets lower indexes override.
  always_comb begin
    hit_pct = '0;
    for (int i = TABLE_CAP - 1; i >= 0; i--) begin
      if (i < TABLE_LEVELS && adc_reading > VOLT_STEPS[i]) begin
        hit_pct = PCT_STEPS[i];
      end
    end
    adc_percent = (hit_pct > PCT_ROUND_UP) ? PCT_FULL : hit_pct;
  end

endmodule

### src/blg_update.sv
// Gauge state registers and the combinational update for one item.
// Depends on blg_pkg.
module blg_update
  import blg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  blg_cfg_t    cfg,
  input  blg_item_t   item,
  input  logic        fire,
  output blg_result_t result
);

  logic [PCT_W-1:0]  level_percent, level_percent_next;
  logic [PCT_W-1:0]  measured_percent, measured_percent_next;
  logic              charger_state, charger_state_next;
  logic              measure_phase, measure_phase_next;
  logic              first_sample, first_sample_next;
  logic [TIME_W-1:0] step_timebase, step_timebase_next;
  logic [CSEC_W-1:0] charge_seconds, charge_seconds_next;
  logic [MCNT_W-1:0] measure_counter, measure_counter_next;

  logic [MCNT_W:0]   mcnt_sum;
  logic [CSEC_W-1:0] csec_sum;
  logic [TIME_W:0]   step_due;
  logic [TIME_W:0]   lp_due;
  logic [PCT_W-1:0]  lvl_inc;
  logic [PCT_W-1:0]  lvl_drop;
  logic              start, shut, wake, exitlp;

  always_comb begin
    level_percent_next    = level_percent;
    measured_percent_next = measured_percent;
    charger_state_next    = charger_state;
    measure_phase_next    = measure_phase;
    first_sample_next     = first_sample;
    step_timebase_next    = step_timebase;
    charge_seconds_next   = charge_seconds;
    measure_counter_next  = measure_counter;
    start  = 1'b0;
    shut   = 1'b0;
    wake   = 1'b0;
    exitlp = 1'b0;

    mcnt_sum = {1'b0, measure_counter} + {2'b00, item.elapsed_sec};
    csec_sum = charge_seconds + {6'd0, item.elapsed_sec};
    step_due = {1'b0, step_timebase} + {1'b0, cfg.charge_step_ms};
    lp_due   = {1'b0, item.low_power_since_ms} + LOW_POWER_DELAY_MS;
    lvl_inc  = level_percent + 7'd1;
    lvl_drop = level_percent;

    if (item.mode == MODE_TICK) begin
      measure_counter_next = (mcnt_sum > {1'b0, COUNTER_MAX}) ? COUNTER_MAX
                                                              : mcnt_sum[MCNT_W-1:0];
      if (item.charger_present) begin
        charge_seconds_next = (csec_sum > CHARGE_SEC_MAX) ? CHARGE_SEC_MAX : csec_sum;
      end
      if (measure_phase) begin
        // A measurement that never delivered a sample times out.
        if (measure_counter_next > MEASURE_TIMEOUT) begin
          measure_phase_next = 1'b0;
        end
      end else begin
        if (item.charger_present) begin
          if (!charger_state) begin
            charger_state_next = 1'b1;
            step_timebase_next = item.time_ms;
            wake = 1'b1;
          end else if ({1'b0, item.time_ms} > step_due) begin
            step_timebase_next = item.time_ms;
            if (level_percent < PCT_FULL) begin
              if (lvl_inc > PCT_HOLD) begin
                // Hold at 99 until the charger has been on long enough.
                if (charge_seconds_next < cfg.full_charge_seconds) begin
                  level_percent_next = PCT_HOLD;
                  if (charge_seconds_next < HOLD_FLOOR_SEC) begin
                    charge_seconds_next = HOLD_FLOOR_SEC;
                  end
                end else begin
                  level_percent_next = PCT_FULL;
                end
              end else begin
                level_percent_next = lvl_inc;
              end
            end
          end
        end else begin
          charge_seconds_next = '0;
          if (charger_state) begin
            charger_state_next = 1'b0;
            step_timebase_next = item.time_ms;
            if (item.low_power_mode && {1'b0, item.time_ms} > lp_due) begin
              lvl_drop = measured_percent;
            end
            level_percent_next = (lvl_drop >= PCT_HOLD) ? PCT_FULL : lvl_drop;
            wake   = 1'b1;
            exitlp = item.low_power_mode;
          end
        end
        if (measure_counter_next > {1'b0, cfg.measure_interval_sec}) begin
          start = 1'b1;
          measure_counter_next = '0;
          measure_phase_next   = 1'b1;
        end
      end
    end else begin
      measured_percent_next = item.adc_percent;
      shut = (item.adc_reading < cfg.shutdown_adc_level) && !item.charger_present;
      if (first_sample) begin
        first_sample_next = 1'b0;
        if (!item.authorized) begin
          level_percent_next = item.adc_percent;
        end
        if (charger_state) begin
          step_timebase_next = item.time_ms;
        end
      end else if (item.adc_percent < level_percent) begin
        level_percent_next = item.adc_percent;
        if (charger_state) begin
          step_timebase_next = item.time_ms;
        end
      end
      measure_phase_next = 1'b0;
    end

    result.battery_percent  = level_percent_next;
    result.charging         = charger_state_next;
    result.low_battery      = !item.charger_present &&
                              (level_percent_next <= cfg.low_battery_percent);
    result.start_measure    = start;
    result.shutdown_request = shut;
    result.display_wake     = wake;
    result.exit_low_power   = exitlp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_percent    <= '0;
      measured_percent <= '0;
      charger_state    <= 1'b0;
      measure_phase    <= 1'b1;
      first_sample     <= 1'b1;
      step_timebase    <= '0;
      charge_seconds   <= '0;
      measure_counter  <= '0;
    end else if (fire) begin
      level_percent    <= level_percent_next;
      measured_percent <= measured_percent_next;
      charger_state    <= charger_state_next;
      measure_phase    <= measure_phase_next;
      first_sample     <= first_sample_next;
      step_timebase    <= step_timebase_next;
      charge_seconds   <= charge_seconds_next;
      measure_counter  <= measure_counter_next;
    end
  end

endmodule

### src/battery_level_gauge_core.sv
// Top level of the battery level gauge: configuration registers, input and
// result registers around the state update. Depends on blg_pkg,
// blg_pct_lookup and blg_update.
//
// Usage: items arrive on the input channel (in_valid / in_stall). A tick
// (mode 0) advances the measurement and charging timers and tracks the
// charger; an ADC sample (mode 1) is converted to a percent and may lower
// or first load the level. Every item yields exactly one result on the
// output channel (out_valid / out_stall). A transfer happens at a rising
// edge with valid high and stall low.
// Path: an accepted item waits in the input register and then goes
// through the update into the result register, which presents it.
// Throughput: one item per cycle while out_stall is low; the state update
// is combinational, so back-to-back items see each other's state directly.
// When the receiver stalls, the result register holds its item, the input
// register holds the next one, and in_stall rises once both are full.
// Configuration: cfg_valid / cfg_ready with a register index and data,
// always ready; write only while no item is in flight.
// Reset (rst, synchronous): both pipeline registers empty, the configuration
// back to defaults, and the gauge at level 0, charger removed, a
// measurement pending and the first sample still expected.
module battery_level_gauge_core
  import blg_pkg::*;
#(
  parameter int TABLE_LEVELS = TABLE_LEVELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [TIME_W-1:0]    time_ms,
  input  logic [SEC_W-1:0]     elapsed_sec,
  input  logic                 charger_present,
  input  logic [ADC_W-1:0]     adc_reading,
  input  logic                 authorized,
  input  logic                 low_power_mode,
  input  logic [TIME_W-1:0]    low_power_since_ms,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PCT_W-1:0]     battery_percent,
  output logic                 charging,
  output logic                 low_battery,
  output logic                 start_measure,
  output logic                 shutdown_request,
  output logic                 display_wake,
  output logic                 exit_low_power,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  blg_cfg_t    cfg;
  blg_item_t   in_item;
  blg_item_t   in_reg;
  logic        in_full, in_full_next;
  logic        in_take;
  logic        advance;
  logic        out_valid_next;
  blg_result_t result;
  blg_result_t out_reg;
  logic [PCT_W-1:0] adc_percent;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_step_ms       <= CHARGE_STEP_MS_RST;
      cfg.measure_interval_sec <= MEASURE_INTERVAL_SEC_RST;
      cfg.low_battery_percent  <= LOW_BATTERY_PERCENT_RST;
      cfg.shutdown_adc_level   <= SHUTDOWN_ADC_LEVEL_RST;
      cfg.full_charge_seconds  <= FULL_CHARGE_SECONDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHARGE_STEP_MS:       cfg.charge_step_ms       <= cfg_data[TIME_W-1:0];
        REG_MEASURE_INTERVAL_SEC: cfg.measure_interval_sec <= cfg_data[SEC_W-1:0];
        REG_LOW_BATTERY_PERCENT:  cfg.low_battery_percent  <= cfg_data[PCT_W-1:0];
        REG_SHUTDOWN_ADC_LEVEL:   cfg.shutdown_adc_level   <= cfg_data[ADC_W-1:0];
        REG_FULL_CHARGE_SECONDS:  cfg.full_charge_seconds  <= cfg_data[CSEC_W-1:0];
        default: ;
      endcase
    end
  end

  // The table lookup depends on the sample alone, so it runs ahead of the
  // input register and keeps the state update short.
  blg_pct_lookup #(
    .TABLE_LEVELS(TABLE_LEVELS)
  ) u_lookup (
    .adc_reading(adc_reading),
    .adc_percent(adc_percent)
  );

  always_comb begin
    in_item.mode               = mode;
    in_item.time_ms            = time_ms;
    in_item.elapsed_sec        = elapsed_sec;
    in_item.charger_present    = charger_present;
    in_item.adc_reading        = adc_reading;
    in_item.authorized         = authorized;
    in_item.low_power_mode     = low_power_mode;
    in_item.low_power_since_ms = low_power_since_ms;
    in_item.adc_percent        = adc_percent;
  end

  // The input item moves on whenever the result register is empty or is
  // being emptied in this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_full_next = in_full;
    if (in_take) begin
      in_full_next = 1'b1;
    end else if (advance) begin
      in_full_next = 1'b0;
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (advance) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full   <= in_full_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_item;
    end
    if (advance) begin
      out_reg <= result;
    end
  end

  blg_update u_update (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .item  (in_reg),
    .fire  (advance),
    .result(result)
  );

  assign battery_percent  = out_reg.battery_percent;
  assign charging         = out_reg.charging;
  assign low_battery      = out_reg.low_battery;
  assign start_measure    = out_reg.start_measure;
  assign shutdown_request = out_reg.shutdown_request;
  assign display_wake     = out_reg.display_wake;
  assign exit_low_power   = out_reg.exit_low_power;

  // The input side only pushes back while it is holding an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with an empty input register");

  // An item that moves into the result stage is presented in the next cycle.
  a_advance_presents: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item not presented");

  // The reported level never leaves the percent range.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> battery_percent <= PCT_FULL)
    else $error("battery level above full");

  // Leaving low power happens only as part of a charger removal.
  a_exit_with_wake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && exit_low_power) |-> (display_wake && !charging))
    else $error("low power exit without charger removal");

endmodule
